[src/heat_stencil_3d_step_assert.svh]
// Assertion macros shared by the stencil RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef HEAT_STENCIL_3D_STEP_ASSERT_SVH
`define HEAT_STENCIL_3D_STEP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define HS3D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define HS3D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/hs3d_pkg.sv]
// Shared types and constants for the 3D heat stencil block.
// No dependencies; imported by every module of the block.
package hs3d_pkg;

	// Default parameter values.
	localparam int MAX_X_DEF     = 64;
	localparam int MAX_Y_DEF     = 64;
	localparam int MAX_Z_DEF     = 1024;
	localparam int TEMP_BITS_DEF = 24;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_SIZE_X    = 3'd0,
		CFG_SIZE_Y    = 3'd1,
		CFG_SIZE_Z    = 3'd2,
		CFG_HEAT_X    = 3'd3,
		CFG_HEAT_Y    = 3'd4,
		CFG_HEAT_Z    = 3'd5,
		CFG_HEAT_EN   = 3'd6,
		CFG_GAIN      = 3'd7
	} cfg_reg_t;

	localparam int CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [6:0]  SIZE_X_RST  = 7'd10;
	localparam logic [6:0]  SIZE_Y_RST  = 7'd10;
	localparam logic [10:0] SIZE_Z_RST  = 11'd10;
	localparam logic [5:0]  HEAT_X_RST  = 6'd2;
	localparam logic [5:0]  HEAT_Y_RST  = 6'd2;
	localparam logic [9:0]  HEAT_Z_RST  = 10'd2;
	localparam logic        HEAT_EN_RST = 1'b1;
	localparam logic [15:0] GAIN_RST    = 16'd10922;

	// Gain is Q0.16; rounding adds half an output LSB before the shift.
	localparam int GAIN_FRAC  = 16;
	localparam int ROUND_HALF = 32768;

	// Result queue depth; it also bounds the results in flight.
	localparam int OUT_DEPTH = 8;

endpackage

[src/hs3d_out_fifo.sv]
// Result queue between the stencil pipeline and the output stream.
// Depends on hs3d_pkg for the queue depth.
module hs3d_out_fifo #(
	parameter int WIDTH = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             valid,
	input  logic             ready,
	output logic [WIDTH-1:0] data
);
	import hs3d_pkg::*;

	localparam int PTRW = $clog2(OUT_DEPTH);
	localparam int CNTW = $clog2(OUT_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [OUT_DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             pop;

	// The head entry is shown whenever the queue holds anything.
	assign valid = (count_q != '0);
	assign data  = entry_q[rd_ptr_q];
	assign pop   = valid && ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			count_q <= count_q + CNTW'(push) - CNTW'(pop);
		end
	end

endmodule

[src/heat_stencil_3d_step.sv]
// One time step of a 7-point 3D heat stencil over a raster-ordered cell stream.
// Depends on hs3d_pkg, hs3d_out_fifo and heat_stencil_3d_step_assert.svh.
//
// Usage: cells enter on the s_axis channel (tuser = kind, 0 for a cell,
// 1 for a drain), x fastest, then y, then z. Each transfer may release one
// result on the m_axis channel; tlast marks the final cell of the grid.
// A result for cell p leaves once cell p + size_x*size_y has been taken, or
// once the whole grid is in; drain transfers then flush the remaining ones.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// any write restarts the pass.
// Throughput: one transfer per cycle while s_axis_tready is high. Each
// transfer writes the incoming cell into two copies of the plane window
// memory and reads four neighbours from them (two read ports per copy); the
// left neighbour and the centre come from a short shift. A released result
// passes the memory read, three pipeline registers and then the queue.
// Stalls: results collect in an eight-entry queue; s_axis_tready drops while
// eight results are pending, so nothing is lost when the receiver stalls.
// Reset clears the positions and loads the default registers; the window
// memory is not cleared, since every cell is written before it is read.
module heat_stencil_3d_step #(
	parameter int MAX_X     = hs3d_pkg::MAX_X_DEF,
	parameter int MAX_Y     = hs3d_pkg::MAX_Y_DEF,
	parameter int MAX_Z     = hs3d_pkg::MAX_Z_DEF,
	parameter int TEMP_BITS = hs3d_pkg::TEMP_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: temperature [TEMP_BITS-1:0], zero padding above.
	input  logic [((TEMP_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
	// tuser: kind [0].
	input  logic                                 s_axis_tuser,
	// Output stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata: new_temperature [TEMP_BITS-1:0], zero padding above.
	output logic [((TEMP_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
	// tlast: last_cell.
	output logic                                 m_axis_tlast,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  hs3d_pkg::cfg_reg_t                   cfg_index,
	input  logic [hs3d_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import hs3d_pkg::*;

	`include "heat_stencil_3d_step_assert.svh"

	localparam int TW        = TEMP_BITS;
	localparam int TDW       = ((TEMP_BITS + 7) / 8) * 8;
	localparam int XW        = $clog2(MAX_X);
	localparam int YW        = $clog2(MAX_Y);
	localparam int ZW        = $clog2(MAX_Z);
	localparam int NXW       = $clog2(MAX_X + 1);
	localparam int NYW       = $clog2(MAX_Y + 1);
	localparam int NZW       = $clog2(MAX_Z + 1);
	localparam int PLANE_MAX = MAX_X * MAX_Y;
	localparam int PW        = $clog2(PLANE_MAX + 1);
	localparam int GPW       = $clog2(PLANE_MAX + 2);
	localparam int WIN       = 2 * MAX_X * MAX_Y + MAX_X + 1;
	localparam int AW        = $clog2(WIN);
	localparam int SW        = TW + 2;
	localparam int DW        = TW + 4;
	localparam int PRW       = DW + GAIN_FRAC + 1;
	localparam int MQW       = PRW + 1 - GAIN_FRAC;
	localparam int RW        = MQW + 1;
	localparam int PENDW     = $clog2(OUT_DEPTH + 1);

	// Configuration registers.
	logic [6:0]  size_x_q, size_y_q;
	logic [10:0] size_z_q;
	logic [5:0]  heat_x_q, heat_y_q;
	logic [9:0]  heat_z_q;
	logic        heat_en_q;
	logic [15:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= SIZE_X_RST;
			size_y_q  <= SIZE_Y_RST;
			size_z_q  <= SIZE_Z_RST;
			heat_x_q  <= HEAT_X_RST;
			heat_y_q  <= HEAT_Y_RST;
			heat_z_q  <= HEAT_Z_RST;
			heat_en_q <= HEAT_EN_RST;
			gain_q    <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE_X:  size_x_q  <= cfg_data[6:0];
				CFG_SIZE_Y:  size_y_q  <= cfg_data[6:0];
				CFG_SIZE_Z:  size_z_q  <= cfg_data[10:0];
				CFG_HEAT_X:  heat_x_q  <= cfg_data[5:0];
				CFG_HEAT_Y:  heat_y_q  <= cfg_data[5:0];
				CFG_HEAT_Z:  heat_z_q  <= cfg_data[9:0];
				CFG_HEAT_EN: heat_en_q <= cfg_data[0];
				CFG_GAIN:    gain_q    <= cfg_data[15:0];
				default:     gain_q    <= gain_q;
			endcase
		end
	end

	// Effective grid extents: zero means one, oversize means the maximum.
	logic [NXW-1:0] nx;
	logic [NYW-1:0] ny;
	logic [NZW-1:0] nz;
	logic [PW-1:0]  plane;

	always_comb begin
		if (size_x_q == '0) begin
			nx = NXW'(1);
		end else if (32'(size_x_q) > MAX_X) begin
			nx = NXW'(MAX_X);
		end else begin
			nx = NXW'(size_x_q);
		end
		if (size_y_q == '0) begin
			ny = NYW'(1);
		end else if (32'(size_y_q) > MAX_Y) begin
			ny = NYW'(MAX_Y);
		end else begin
			ny = NYW'(size_y_q);
		end
		if (size_z_q == '0) begin
			nz = NZW'(1);
		end else if (32'(size_z_q) > MAX_Z) begin
			nz = NZW'(MAX_Z);
		end else begin
			nz = NZW'(size_z_q);
		end
		plane = PW'(nx) * PW'(ny);
	end

	// Stream positions: input side, output side and the gap between them.
	logic [XW-1:0]  ix_q, ox_q;
	logic [YW-1:0]  iy_q, oy_q;
	logic [ZW-1:0]  iz_q, oz_q;
	logic           in_done_q;
	logic [GPW-1:0] gap_q;
	logic [AW-1:0]  wp_q, cp_q;
	logic [PENDW-1:0] pend_q;

	logic          in_xfer, wr, in_last, in_zero, done_n, fire;
	logic          ox_first, ox_last, oy_first, oy_last, oz_first, oz_last, out_last;
	logic          heat_hit;
	logic [GPW-1:0] gap_inc;
	logic [TW-1:0] temp_in;
	logic          out_pop;

	assign s_axis_tready = (pend_q < PENDW'(OUT_DEPTH));
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign temp_in       = s_axis_tdata[TW-1:0];

	// Transfer decode: write the cell, then decide whether a result is due.
	always_comb begin
		wr       = in_xfer && !s_axis_tuser && !in_done_q;
		in_last  = (ix_q == XW'(nx - NXW'(1))) && (iy_q == YW'(ny - NYW'(1)))
			&& (iz_q == ZW'(nz - NZW'(1)));
		in_zero  = (ix_q == '0) && (iy_q == '0) && (iz_q == '0);
		done_n   = in_done_q || (wr && in_last);
		gap_inc  = gap_q + GPW'(wr);
		fire     = in_xfer && (done_n || (gap_inc > GPW'(plane)));
		ox_first = (ox_q == '0);
		ox_last  = (ox_q == XW'(nx - NXW'(1)));
		oy_first = (oy_q == '0);
		oy_last  = (oy_q == YW'(ny - NYW'(1)));
		oz_first = (oz_q == '0);
		oz_last  = (oz_q == ZW'(nz - NZW'(1)));
		out_last = ox_last && oy_last && oz_last;
		heat_hit = heat_en_q && (32'(ox_q) == 32'(heat_x_q))
			&& (32'(oy_q) == 32'(heat_y_q)) && (32'(oz_q) == 32'(heat_z_q));
	end

	// Neighbour addresses in the circular window.
	logic [AW:0]   right_sum, south_sum, north_sum, below_sum;
	logic [AW-1:0] ra_right, ra_south, ra_north, ra_below, wp_next, cp_next;

	always_comb begin
		right_sum = {1'b0, cp_q} + (AW+1)'(1);
		south_sum = {1'b0, cp_q} + (AW+1)'(nx);
		north_sum = {1'b0, cp_q} + (AW+1)'(WIN) - (AW+1)'(nx);
		below_sum = {1'b0, cp_q} + (AW+1)'(WIN) - (AW+1)'(plane);
		ra_right  = (right_sum >= (AW+1)'(WIN)) ? AW'(right_sum - (AW+1)'(WIN))
			: AW'(right_sum);
		ra_south  = (south_sum >= (AW+1)'(WIN)) ? AW'(south_sum - (AW+1)'(WIN))
			: AW'(south_sum);
		ra_north  = (north_sum >= (AW+1)'(WIN)) ? AW'(north_sum - (AW+1)'(WIN))
			: AW'(north_sum);
		ra_below  = (below_sum >= (AW+1)'(WIN)) ? AW'(below_sum - (AW+1)'(WIN))
			: AW'(below_sum);
		wp_next   = (wp_q == AW'(WIN - 1)) ? '0 : wp_q + AW'(1);
		cp_next   = (cp_q == AW'(WIN - 1)) ? '0 : cp_q + AW'(1);
	end

	// Position counters; a config write or the end of a pass restarts them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix_q      <= '0;
			iy_q      <= '0;
			iz_q      <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			oz_q      <= '0;
			in_done_q <= 1'b0;
			gap_q     <= '0;
			wp_q      <= '0;
			cp_q      <= '0;
		end else if (cfg_we || (fire && out_last)) begin
			ix_q      <= '0;
			iy_q      <= '0;
			iz_q      <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			oz_q      <= '0;
			in_done_q <= 1'b0;
			gap_q     <= '0;
			wp_q      <= '0;
			cp_q      <= '0;
		end else begin
			if (wr) begin
				wp_q      <= wp_next;
				in_done_q <= done_n;
				if (ix_q == XW'(nx - NXW'(1))) begin
					ix_q <= '0;
					if (iy_q == YW'(ny - NYW'(1))) begin
						iy_q <= '0;
						iz_q <= oz_last && in_last ? '0 : iz_q + ZW'(1);
					end else begin
						iy_q <= iy_q + YW'(1);
					end
				end else begin
					ix_q <= ix_q + XW'(1);
				end
			end
			if (fire) begin
				cp_q <= cp_next;
				if (ox_last) begin
					ox_q <= '0;
					if (oy_last) begin
						oy_q <= '0;
						oz_q <= oz_q + ZW'(1);
					end else begin
						oy_q <= oy_q + YW'(1);
					end
				end else begin
					ox_q <= ox_q + XW'(1);
				end
			end
			gap_q <= gap_inc - GPW'(fire);
		end
	end

	// Two copies of the plane window, each with two read ports.
	logic [TW-1:0] win_a [WIN];
	logic [TW-1:0] win_b [WIN];
	logic [TW-1:0] rd_right_s1, rd_south_s1, rd_north_s1, rd_below_s1;
	logic [TW-1:0] first_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			win_a[wp_q] <= temp_in;
		end
		rd_right_s1 <= win_a[ra_right];
		rd_south_s1 <= win_a[ra_south];
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			win_b[wp_q] <= temp_in;
		end
		rd_north_s1 <= win_b[ra_north];
		rd_below_s1 <= win_b[ra_below];
	end

	// First cell of the pass, kept for the start of the output shift.
	always_ff @(posedge clk) begin
		if (wr && in_zero) begin
			first_q <= temp_in;
		end
	end

	// Stage 1 payload: edges, source match, forwarding of same-cycle writes.
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          x0_s1, xl_s1, y0_s1, yl_s1, z0_s1, zl_s1, hold_s1, last_s1, pzero_s1;
	logic          byp_right_s1, byp_south_s1, byp_north_s1, byp_below_s1;
	logic [TW-1:0] byp_s1, first_s1;

	always_ff @(posedge clk) begin
		x0_s1        <= ox_first;
		xl_s1        <= ox_last;
		y0_s1        <= oy_first;
		yl_s1        <= oy_last;
		z0_s1        <= oz_first;
		zl_s1        <= oz_last;
		hold_s1      <= heat_hit;
		last_s1      <= out_last;
		pzero_s1     <= ox_first && oy_first && oz_first;
		byp_s1       <= temp_in;
		first_s1     <= (wr && in_zero) ? temp_in : first_q;
		byp_right_s1 <= wr && (ra_right == wp_q);
		byp_south_s1 <= wr && (ra_south == wp_q);
		byp_north_s1 <= wr && (ra_north == wp_q);
		byp_below_s1 <= wr && (ra_below == wp_q);
	end

	// Stage 1: assemble the neighbourhood and form two partial sums.
	logic [TW-1:0] right_v, south_v, north_v, below_v, center_v, left_v;
	logic [TW-1:0] right_prev_q, center_prev_q;
	logic [SW-1:0] part_a, part_b;
	logic [SW-1:0] sa_s2, sb_s2;
	logic [TW-1:0] tc_s2;
	logic          hold_s2, last_s2;

	always_comb begin
		right_v  = byp_right_s1 ? byp_s1 : rd_right_s1;
		south_v  = byp_south_s1 ? byp_s1 : rd_south_s1;
		north_v  = byp_north_s1 ? byp_s1 : rd_north_s1;
		below_v  = byp_below_s1 ? byp_s1 : rd_below_s1;
		center_v = pzero_s1 ? first_s1 : right_prev_q;
		left_v   = center_prev_q;
		part_a   = SW'(x0_s1 ? center_v : left_v) + SW'(xl_s1 ? center_v : right_v)
			+ SW'(y0_s1 ? center_v : north_v);
		part_b   = SW'(yl_s1 ? center_v : south_v) + SW'(z0_s1 ? center_v : below_v)
			+ SW'(zl_s1 ? center_v : byp_s1);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			right_prev_q  <= right_v;
			center_prev_q <= center_v;
		end
		sa_s2   <= part_a;
		sb_s2   <= part_b;
		tc_s2   <= center_v;
		hold_s2 <= hold_s1;
		last_s2 <= last_s1;
	end

	// Stage 2: Laplacian, sum of neighbours minus six times the centre.
	logic [DW-1:0]        tc6;
	logic signed [DW-1:0] lap_s3;
	logic [TW-1:0]        tc_s3;
	logic                 hold_s3, last_s3;

	assign tc6 = (DW'(tc_s2) << 2) + (DW'(tc_s2) << 1);

	always_ff @(posedge clk) begin
		lap_s3  <= $signed(DW'(sa_s2) + DW'(sb_s2) - tc6);
		tc_s3   <= tc_s2;
		hold_s3 <= hold_s2;
		last_s3 <= last_s2;
	end

	// Stage 3: scale by the diffusion gain.
	logic signed [PRW-1:0] prod_s4;
	logic [TW-1:0]         tc_s4;
	logic                  hold_s4, last_s4;

	always_ff @(posedge clk) begin
		prod_s4 <= PRW'(lap_s3) * $signed({1'b0, gain_q});
		tc_s4   <= tc_s3;
		hold_s4 <= hold_s3;
		last_s4 <= last_s3;
	end

	// Stage 4: round to nearest, ties away from zero, add and saturate; a source cell keeps its value.
	logic                 neg;
	logic [PRW-1:0]       mag;
	logic [PRW:0]         rsum;
	logic [MQW-1:0]       mq;
	logic signed [RW-1:0] res;
	logic [TW-1:0]        sat, new_temp;

	always_comb begin
		neg  = prod_s4[PRW-1];
		mag  = neg ? PRW'(-prod_s4) : PRW'(prod_s4);
		rsum = {1'b0, mag} + (PRW+1)'(ROUND_HALF);
		mq   = rsum[PRW:GAIN_FRAC];
		res  = neg ? $signed(RW'(tc_s4)) - $signed(RW'(mq))
			: $signed(RW'(tc_s4)) + $signed(RW'(mq));
		if (res < 0) begin
			sat = '0;
		end else if (res > $signed(RW'({TW{1'b1}}))) begin
			sat = {TW{1'b1}};
		end else begin
			sat = res[TW-1:0];
		end
		new_temp = hold_s4 ? tc_s4 : sat;
	end

	// Stage valid bits and the count of results not yet transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			pend_q <= '0;
		end else begin
			v_s1   <= fire;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			pend_q <= pend_q + PENDW'(fire) - PENDW'(out_pop);
		end
	end

	// Result queue toward the output stream.
	logic [TW:0] q_data;

	hs3d_out_fifo #(
		.WIDTH(TW + 1)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s4),
		.push_data({last_s4, new_temp}),
		.valid    (m_axis_tvalid),
		.ready    (m_axis_tready),
		.data     (q_data)
	);

	assign out_pop      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = TDW'(q_data[TW-1:0]);
	assign m_axis_tlast = q_data[TW];

	// Checks on the block's own bookkeeping.
	`HS3D_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= PENDW'(OUT_DEPTH), "result credit overrun")
	`HS3D_ASSERT_NOW(a_gap_window, !in_done_q, gap_q <= GPW'(plane), "input ran ahead of window")
	`HS3D_ASSERT_NEXT(a_pass_restart, fire && out_last && !cfg_we,
		(ox_q == '0) && (gap_q == '0) && !in_done_q, "pass did not restart")

endmodule
